// File: sv/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants of the generational handle table: the request
// and response words, command and status codes, controller states and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ght_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int DATA_W_DEF   = 32;
   localparam int GEN_W        = 32;

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_DEL  = 2'd1,
      CMD_LOOK = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OOB   = 2'd1,
      STAT_STALE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] handle_index;
      logic [31:0] handle_gen;
      logic [31:0] data_in;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  out_index;
      logic [31:0] out_gen;
      logic [31:0] data_out;
      logic [8:0]  live_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_MOVE,
      S_LOOK,
      S_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic rd;
      logic exec;
      logic move;
      logic look;
      logic emit;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic need_move;
      logic need_look;
      logic rsp_free;
   } sts_type;

endpackage

// File: sv/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// Sequencer of the handle table: walks each request word through read,
// execute, the optional move or lookup step and the hand-off to the
// response register.
// ----------------------------------------------------------------------------
module ght_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ght_pkg::sts_type sts,
   output ght_pkg::ctl_type ctl
);
   import ght_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctl       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            ctl.rd   = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            priority if (sts.need_move) begin
               state_in = S_MOVE;
            end else if (sts.need_look) begin
               state_in = S_LOOK;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_MOVE: begin
            ctl.move = 1'b1;
            state_in = S_EMIT;
         end
         S_LOOK: begin
            ctl.look = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: sv/ght_dp.sv
// ----------------------------------------------------------------------------
// ght_dp
// Datapath of the handle table: slot generation and link memories, dense
// word store, dense-to-slot owner memory, free chain head, element count,
// high-water mark of touched slots and the response register.
// ----------------------------------------------------------------------------
module ght_dp #(
   parameter int CAPACITY = ght_pkg::CAPACITY_DEF,
   parameter int DATA_W   = ght_pkg::DATA_W_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ght_pkg::req_type req_word,
   output ght_pkg::rsp_type rsp_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ght_pkg::ctl_type ctl,
   output ght_pkg::sts_type sts
);
   import ght_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // memories
   logic [GEN_W-1:0]  gen_mem   [CAPACITY];
   logic [CW-1:0]     link_mem  [CAPACITY];
   logic [DATA_W-1:0] dense_mem [CAPACITY];
   logic [IW-1:0]     owner_mem [CAPACITY];

   logic [GEN_W-1:0]  gen_rd;
   logic [CW-1:0]     link_rd;
   logic [DATA_W-1:0] dense_rd;
   logic [IW-1:0]     owner_rd;

   logic              gen_we, gen_re;
   logic [GEN_W-1:0]  gen_wdata;
   logic              link_we, link_re;
   logic [IW-1:0]     link_addr;
   logic [CW-1:0]     link_wdata;
   logic              dense_we, dense_re;
   logic [IW-1:0]     dense_addr;
   logic [DATA_W-1:0] dense_wdata;
   logic              owner_we, owner_re;
   logic [IW-1:0]     owner_addr;
   logic [IW-1:0]     owner_wdata;

   // registers
   req_type           req_ff;
   logic [CW-1:0]     free_head_ff, free_head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     hwm_ff, hwm_in;
   logic [IW-1:0]     dpos_ff;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // decode
   logic [IW-1:0]     s_idx;
   logic              s_fresh;
   logic [GEN_W-1:0]  eff_gen;
   logic [CW-1:0]     eff_link;
   logic [IW-1:0]     dpos;
   logic [IW-1:0]     last;
   logic              oob, chk_ok, full;
   logic              add_ok, del_ok, look_ok, del_move;

   always_comb begin
      s_idx    = (req_ff.cmd == CMD_ADD) ? free_head_ff[IW-1:0]
                                         : req_ff.handle_index[IW-1:0];
      // slots at or above the high-water mark were never written
      s_fresh  = CW'(s_idx) >= hwm_ff;
      eff_gen  = s_fresh ? '0 : gen_rd;
      eff_link = s_fresh ? CW'(CW'(s_idx) + 1'b1) : link_rd;
      dpos     = eff_link[IW-1:0];
      last     = IW'(count_ff - 1'b1);
      oob      = req_ff.handle_index >= 32'(CAPACITY);
      chk_ok   = !oob && (eff_gen == req_ff.handle_gen) && (eff_link < count_ff);
      full     = (free_head_ff >= CW'(CAPACITY)) || (count_ff >= CW'(CAPACITY));
      add_ok   = (req_ff.cmd == CMD_ADD) && !full;
      del_ok   = (req_ff.cmd == CMD_DEL) && chk_ok;
      look_ok  = (req_ff.cmd == CMD_LOOK) && chk_ok;
      del_move = del_ok && (dpos != last);
   end

   assign sts.need_move = del_move;
   assign sts.need_look = look_ok;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   // memory port control
   always_comb begin
      gen_re      = ctl.rd;
      gen_we      = ctl.exec && (add_ok || del_ok);
      gen_wdata   = add_ok ? eff_gen : GEN_W'(eff_gen + 1'b1);

      link_re     = ctl.rd;
      link_we     = (ctl.exec && (add_ok || del_ok)) || ctl.move;
      link_addr   = ctl.move ? owner_rd : s_idx;
      link_wdata  = ctl.move ? CW'(dpos_ff) : (add_ok ? count_ff : free_head_ff);

      dense_re    = ctl.exec && (del_move || look_ok);
      dense_we    = (ctl.exec && add_ok) || ctl.move;
      dense_wdata = ctl.move ? dense_rd : DATA_W'(req_ff.data_in);
      priority if (ctl.move) begin
         dense_addr = dpos_ff;
      end else if (add_ok) begin
         dense_addr = count_ff[IW-1:0];
      end else if (del_ok) begin
         dense_addr = last;
      end else begin
         dense_addr = dpos;
      end

      owner_re    = ctl.rd;
      owner_we    = (ctl.exec && add_ok) || ctl.move;
      owner_wdata = ctl.move ? owner_rd : s_idx;
      priority if (ctl.move) begin
         owner_addr = dpos_ff;
      end else if (ctl.exec) begin
         owner_addr = count_ff[IW-1:0];
      end else begin
         owner_addr = last;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[s_idx] <= gen_wdata;
      end
      if (gen_re) begin
         gen_rd <= gen_mem[s_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_addr] <= link_wdata;
      end
      if (link_re) begin
         link_rd <= link_mem[link_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dense_we) begin
         dense_mem[dense_addr] <= dense_wdata;
      end
      if (dense_re) begin
         dense_rd <= dense_mem[dense_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[owner_addr] <= owner_wdata;
      end
      if (owner_re) begin
         owner_rd <= owner_mem[owner_addr];
      end
   end

   // table state and result
   always_comb begin
      free_head_in = free_head_ff;
      count_in     = count_ff;
      hwm_in       = hwm_ff;
      res_in       = res_ff;
      if (ctl.exec) begin
         if (add_ok) begin
            free_head_in = eff_link;
            count_in     = CW'(count_ff + 1'b1);
            if (s_fresh) begin
               hwm_in = CW'(CW'(s_idx) + 1'b1);
            end
         end else if (del_ok) begin
            free_head_in = CW'(s_idx);
            count_in     = CW'(count_ff - 1'b1);
         end
         res_in.out_index  = '0;
         res_in.out_gen    = '0;
         res_in.data_out   = '0;
         res_in.live_count = 9'(count_in);
         unique case (req_ff.cmd)
            CMD_ADD: begin
               res_in.status = full ? STAT_FULL : STAT_OK;
               if (add_ok) begin
                  res_in.out_index = 8'(s_idx);
                  res_in.out_gen   = eff_gen;
               end
            end
            CMD_DEL, CMD_LOOK: begin
               priority if (oob) begin
                  res_in.status = STAT_OOB;
               end else if (!chk_ok) begin
                  res_in.status = STAT_STALE;
               end else begin
                  res_in.status = STAT_OK;
               end
            end
            CMD_NOP: begin
               res_in.status = STAT_OK;
            end
            default: begin
               res_in.status = STAT_OK;
            end
         endcase
      end
      if (ctl.look) begin
         res_in.data_out = 32'(dense_rd);
      end
   end

   assign rsp_valid_in = ctl.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         count_ff     <= '0;
         hwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         hwm_ff       <= hwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_word;
      end
      if (ctl.exec) begin
         dpos_ff <= dpos;
      end
      res_ff <= res_in;
      if (ctl.emit) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_word  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Fixed-capacity slot map with generation counters: add, delete and lookup
// by handle over a free chain and a dense word store.
//
//   channel   ports                      direction   one word is
//   request   req_valid/ready, req_word  in          one command
//   response  rsp_valid/ready, rsp_word  out         one result per command
//
// A command runs through read, execute and hand-off (add, failed delete or
// lookup, delete of the last dense word, unused code) or through read, execute,
// a move or lookup step and hand-off (lookup hit, delete that fills the hole
// with the last dense word); the single-port slot, dense and owner memories set the steps.
// A new command is taken while the previous result waits in the response
// register; a stalled response holds the next result at its hand-off step.
// Reset is immediate: slots at or above a high-water mark read as never written.
// ----------------------------------------------------------------------------
module generational_handle_table #(
   parameter int CAPACITY = ght_pkg::CAPACITY_DEF,
   parameter int DATA_W   = ght_pkg::DATA_W_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ght_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ght_pkg::rsp_type rsp_word
);
   import ght_pkg::*;

   ctl_type ctl;
   sts_type sts;

   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ght_dp #(
      .CAPACITY (CAPACITY),
      .DATA_W   (DATA_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

endmodule
